// ===== rtl/psd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Register indexes on the configuration port.
    localparam cfg_idx_t REG_THRESHOLD    = 3'd0;
    localparam cfg_idx_t REG_MIN_INTERVAL = 3'd1;
    localparam cfg_idx_t REG_MAX_HIGH     = 3'd2;
    localparam cfg_idx_t REG_MIN_SWING    = 3'd3;
    localparam cfg_idx_t REG_SMOOTHING    = 3'd4;

    // Register reset values.
    localparam logic [15:0] THRESHOLD_RESET    = 16'd1150;
    localparam logic [15:0] MIN_INTERVAL_RESET = 16'd500;
    localparam logic [15:0] MAX_HIGH_RESET     = 16'd2000;
    localparam logic [15:0] MIN_SWING_RESET    = 16'd150;
    localparam logic [8:0]  SMOOTHING_RESET    = 9'd51;

    typedef struct packed {
        logic [15:0] threshold_mg;
        logic [15:0] min_interval_ms;
        logic [15:0] max_high_ms;
        logic [15:0] min_swing_mg;
        logic [8:0]  smoothing_q8;
    } cfg_regs_t;

    // Datapath constants.
    localparam logic [23:0] LEVEL_RESET  = 24'd256000;
    localparam logic [23:0] TROUGH_RESET = 24'd512000;
    localparam logic [18:0] STRIDE_NUM   = 19'd375000;
    localparam logic [10:0] STRIDE_MIN   = 11'd400;
    localparam logic [10:0] STRIDE_MAX   = 11'd1200;
    localparam logic [8:0]  WEIGHT_FULL  = 9'd256;
    localparam logic [32:0] ROUND_HALF   = 33'd128;

    // Loop counter start values: the loop runs one more time than the start value.
    localparam logic [4:0] SQRT_LAST = 5'd15;
    localparam logic [4:0] DIV_LAST  = 5'd18;

    // Program addresses.
    typedef logic [4:0] step_t;

    localparam step_t ST_IDLE      = 5'd0;
    localparam step_t ST_SQ_X      = 5'd1;
    localparam step_t ST_SQ_Y      = 5'd2;
    localparam step_t ST_SQ_Z      = 5'd3;
    localparam step_t ST_SUM       = 5'd4;
    localparam step_t ST_SQRT_INIT = 5'd5;
    localparam step_t ST_SQRT_LOOP = 5'd6;
    localparam step_t ST_FLT_A     = 5'd7;
    localparam step_t ST_FLT_B     = 5'd8;
    localparam step_t ST_FLT_C     = 5'd9;
    localparam step_t ST_LEVEL     = 5'd10;
    localparam step_t ST_EXTREMES  = 5'd11;
    localparam step_t ST_TIMEOUT   = 5'd12;
    localparam step_t ST_EDGE      = 5'd13;
    localparam step_t ST_FALL      = 5'd14;
    localparam step_t ST_DIV_INIT  = 5'd15;
    localparam step_t ST_DIV_LOOP  = 5'd16;
    localparam step_t ST_CLAMP     = 5'd17;
    localparam step_t ST_DIST      = 5'd18;
    localparam step_t ST_FINISH    = 5'd19;

    // Datapath operation of one step.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQRT_INIT,
        OP_SQRT_ITER,
        OP_LEVEL,
        OP_EXTREMES,
        OP_TIMEOUT,
        OP_EDGE,
        OP_FALL,
        OP_DIV_INIT,
        OP_DIV_ITER,
        OP_CLAMP,
        OP_DIST,
        OP_EMIT
    } dp_op_t;

    // Multiplier operand selection.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SQX,
        MUL_SQY,
        MUL_SQZ,
        MUL_FNEW,
        MUL_FOLD
    } mul_sel_t;

    // Accumulator operation.
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_LOAD_RND
    } acc_op_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_FIRE,
        COND_LOOP,
        COND_NO_FALL,
        COND_NO_STEP,
        COND_OUT_FREE
    } cond_t;

    // One control word of the program.
    typedef struct packed {
        dp_op_t   op;
        mul_sel_t mul;
        acc_op_t  acc;
        cond_t    cond;
        logic     stay;
        step_t    target;
    } ucode_t;

    // Datapath flags seen by the sequencer.
    typedef struct packed {
        logic fire;
        logic loop;
        logic fall;
        logic step_ok;
        logic out_free;
    } status_t;

    // Control store.
    function automatic ucode_t ucode(input step_t step);
        ucode_t w;
        w = '{op: OP_NONE, mul: MUL_NONE, acc: ACC_HOLD, cond: COND_NEVER,
              stay: 1'b0, target: ST_IDLE};
        case (step)
            ST_IDLE:
            begin
                w.op     = OP_LOAD;
                w.cond   = COND_FIRE;
                w.stay   = 1'b1;
                w.target = ST_SQ_X;
            end
            ST_SQ_X:
            begin
                w.mul = MUL_SQX;
            end
            ST_SQ_Y:
            begin
                w.mul = MUL_SQY;
                w.acc = ACC_LOAD;
            end
            ST_SQ_Z:
            begin
                w.mul = MUL_SQZ;
                w.acc = ACC_ADD;
            end
            ST_SUM:
            begin
                w.acc = ACC_ADD;
            end
            ST_SQRT_INIT:
            begin
                w.op = OP_SQRT_INIT;
            end
            ST_SQRT_LOOP:
            begin
                w.op     = OP_SQRT_ITER;
                w.cond   = COND_LOOP;
                w.target = ST_SQRT_LOOP;
            end
            ST_FLT_A:
            begin
                w.mul = MUL_FNEW;
            end
            ST_FLT_B:
            begin
                w.mul = MUL_FOLD;
                w.acc = ACC_LOAD_RND;
            end
            ST_FLT_C:
            begin
                w.acc = ACC_ADD;
            end
            ST_LEVEL:
            begin
                w.op = OP_LEVEL;
            end
            ST_EXTREMES:
            begin
                w.op = OP_EXTREMES;
            end
            ST_TIMEOUT:
            begin
                w.op = OP_TIMEOUT;
            end
            ST_EDGE:
            begin
                w.op     = OP_EDGE;
                w.cond   = COND_NO_FALL;
                w.target = ST_FINISH;
            end
            ST_FALL:
            begin
                w.op = OP_FALL;
            end
            ST_DIV_INIT:
            begin
                w.op     = OP_DIV_INIT;
                w.cond   = COND_NO_STEP;
                w.target = ST_FINISH;
            end
            ST_DIV_LOOP:
            begin
                w.op     = OP_DIV_ITER;
                w.cond   = COND_LOOP;
                w.target = ST_DIV_LOOP;
            end
            ST_CLAMP:
            begin
                w.op = OP_CLAMP;
            end
            ST_DIST:
            begin
                w.op = OP_DIST;
            end
            ST_FINISH:
            begin
                w.op     = OP_EMIT;
                w.cond   = COND_OUT_FREE;
                w.stay   = 1'b1;
                w.target = ST_IDLE;
            end
            default:
            begin
                w.cond   = COND_FIRE;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/psd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sample channel: one beat per accelerometer sample.
interface psd_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0]        time_ms;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    output time_ms, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    input time_ms, output ready);
endinterface

// Result channel: one beat per sample.
interface psd_result_if;
    logic        valid;
    logic        ready;
    logic        step_event;
    logic [10:0] step_length_mm;
    logic [31:0] steps_total;
    logic [31:0] distance_mm;
    logic [23:0] smoothed_magnitude;

    modport source (output valid, output step_event, output step_length_mm,
                    output steps_total, output distance_mm,
                    output smoothed_magnitude, input ready);
    modport sink   (input valid, input step_event, input step_length_mm,
                    input steps_total, input distance_mm,
                    input smoothed_magnitude, output ready);
endinterface

// Configuration write channel.
interface psd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [psd_pkg::CFG_IDX_W-1:0]   index;
    logic [psd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/psd_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module psd_sequencer
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire psd_pkg::status_t status,
    output psd_pkg::ucode_t       ctrl
);

    psd_pkg::step_t pc_reg;
    psd_pkg::step_t pc_next;
    logic           take;

    // Fetch the control word of the current step.
    always_comb
    begin
        ctrl = psd_pkg::ucode(pc_reg);
    end

    // Evaluate the jump condition.
    always_comb
    begin
        case (ctrl.cond)
            psd_pkg::COND_NEVER:    take = 1'b0;
            psd_pkg::COND_FIRE:     take = status.fire;
            psd_pkg::COND_LOOP:     take = status.loop;
            psd_pkg::COND_NO_FALL:  take = !status.fall;
            psd_pkg::COND_NO_STEP:  take = !status.step_ok;
            psd_pkg::COND_OUT_FREE: take = status.out_free;
            default:                take = 1'b0;
        endcase
    end

    // Next step: jump, hold, or fall through.
    always_comb
    begin
        if (take)
        begin
            pc_next = ctrl.target;
        end
        else if (ctrl.stay)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + 5'd1;
        end
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= psd_pkg::ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/psd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module psd_datapath
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire psd_pkg::cfg_regs_t cfg_regs,
    input  wire psd_pkg::ucode_t    ctrl,
    output psd_pkg::status_t        status,
    psd_sample_if.sink              samples,
    psd_result_if.source            results
);

    // Sample registers.
    logic signed [15:0] ax_reg;
    logic signed [15:0] ay_reg;
    logic signed [15:0] az_reg;
    logic [31:0]        now_reg;

    // Multiplier and accumulator.
    logic [23:0] mul_a;
    logic [15:0] mul_b;
    logic [39:0] prod_reg;
    logic [32:0] acc_reg;
    logic [32:0] acc_next;

    // Square root and divider state.
    logic [31:0] rad_reg;
    logic [17:0] rem_reg;
    logic [15:0] root_reg;
    logic [4:0]  cnt_reg;
    logic [18:0] num_reg;
    logic [18:0] drem_reg;

    // Detector state.
    logic [23:0] filt_reg;
    logic [23:0] peak_reg;
    logic [23:0] trough_reg;
    logic        armed_reg;
    logic [31:0] rise_reg;
    logic [31:0] last_reg;
    logic        tmo_reg;
    logic [31:0] elap_reg;
    logic        ok_reg;
    logic        event_reg;
    logic [10:0] stride_reg;
    logic [31:0] tally_reg;
    logic [31:0] dist_reg;

    // Output register.
    logic        out_valid_reg;
    logic        out_event_reg;
    logic [10:0] out_stride_reg;
    logic [31:0] out_tally_reg;
    logic [31:0] out_dist_reg;
    logic [23:0] out_level_reg;

    // Combinational helpers.
    logic        fire;
    logic        out_free;
    logic        emit;
    logic [15:0] abs_x;
    logic [15:0] abs_y;
    logic [15:0] abs_z;
    logic [8:0]  w_new;
    logic [8:0]  w_old;
    logic [23:0] thr_q;
    logic [19:0] sq_trial;
    logic [19:0] sq_sub;
    logic        sq_ge;
    logic [19:0] sq_diff;
    logic [19:0] dv_trial;
    logic        dv_ge;
    logic [19:0] dv_diff;
    logic [31:0] rise_delta;
    logic        swing_ok;
    logic [10:0] stride_clamp;
    logic [32:0] dist_sum;

    // Handshakes.
    assign samples.ready = (ctrl.op == psd_pkg::OP_LOAD);
    assign fire          = samples.valid && samples.ready;
    assign out_free      = !out_valid_reg || results.ready;
    assign emit          = (ctrl.op == psd_pkg::OP_EMIT) && out_free;

    assign status.fire     = fire;
    assign status.loop     = (cnt_reg != 5'd0);
    assign status.fall     = armed_reg && (filt_reg < thr_q);
    assign status.step_ok  = ok_reg;
    assign status.out_free = out_free;

    // Magnitudes of the axes and filter weights.
    assign abs_x = ax_reg[15] ? 16'(-ax_reg) : ax_reg;
    assign abs_y = ay_reg[15] ? 16'(-ay_reg) : ay_reg;
    assign abs_z = az_reg[15] ? 16'(-az_reg) : az_reg;
    assign w_new = (cfg_regs.smoothing_q8 > psd_pkg::WEIGHT_FULL) ?
                   psd_pkg::WEIGHT_FULL : cfg_regs.smoothing_q8;
    assign w_old = psd_pkg::WEIGHT_FULL - w_new;
    assign thr_q = {cfg_regs.threshold_mg, 8'd0};

    // Multiplier operand selection.
    always_comb
    begin
        case (ctrl.mul)
            psd_pkg::MUL_SQX:
            begin
                mul_a = {8'd0, abs_x};
                mul_b = abs_x;
            end
            psd_pkg::MUL_SQY:
            begin
                mul_a = {8'd0, abs_y};
                mul_b = abs_y;
            end
            psd_pkg::MUL_SQZ:
            begin
                mul_a = {8'd0, abs_z};
                mul_b = abs_z;
            end
            psd_pkg::MUL_FNEW:
            begin
                mul_a = {root_reg, 8'd0};
                mul_b = {7'd0, w_new};
            end
            psd_pkg::MUL_FOLD:
            begin
                mul_a = filt_reg;
                mul_b = {7'd0, w_old};
            end
            default:
            begin
                mul_a = 24'd0;
                mul_b = 16'd0;
            end
        endcase
    end

    // Accumulator next value.
    always_comb
    begin
        case (ctrl.acc)
            psd_pkg::ACC_LOAD:     acc_next = prod_reg[32:0];
            psd_pkg::ACC_ADD:      acc_next = acc_reg + prod_reg[32:0];
            psd_pkg::ACC_LOAD_RND: acc_next = prod_reg[32:0] + psd_pkg::ROUND_HALF;
            default:               acc_next = acc_reg;
        endcase
    end

    // One digit of the square root: two radicand bits per step.
    assign sq_trial = {rem_reg, rad_reg[31:30]};
    assign sq_sub   = {2'd0, root_reg, 2'b01};
    assign sq_ge    = (sq_trial >= sq_sub);
    assign sq_diff  = sq_trial - sq_sub;

    // One bit of the stride division.
    assign dv_trial = {drem_reg, num_reg[18]};
    assign dv_ge    = ({12'd0, dv_trial} >= elap_reg);
    assign dv_diff  = dv_trial - elap_reg[19:0];

    // Detector comparisons.
    assign rise_delta = now_reg - rise_reg;
    assign swing_ok   = (peak_reg > trough_reg) &&
                        ((peak_reg - trough_reg) > {cfg_regs.min_swing_mg, 8'd0});

    // Stride limits and saturating distance.
    always_comb
    begin
        if (num_reg < {8'd0, psd_pkg::STRIDE_MIN})
        begin
            stride_clamp = psd_pkg::STRIDE_MIN;
        end
        else if (num_reg > {8'd0, psd_pkg::STRIDE_MAX})
        begin
            stride_clamp = psd_pkg::STRIDE_MAX;
        end
        else
        begin
            stride_clamp = num_reg[10:0];
        end
    end

    assign dist_sum = {1'b0, dist_reg} + {22'd0, stride_reg};

    // Detector state and counters, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg      <= psd_pkg::LEVEL_RESET;
            peak_reg      <= 24'd0;
            trough_reg    <= psd_pkg::TROUGH_RESET;
            armed_reg     <= 1'b0;
            rise_reg      <= 32'd0;
            last_reg      <= 32'd0;
            tally_reg     <= 32'd0;
            dist_reg      <= 32'd0;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (ctrl.op)
                psd_pkg::OP_SQRT_INIT:
                begin
                    cnt_reg <= psd_pkg::SQRT_LAST;
                end
                psd_pkg::OP_SQRT_ITER, psd_pkg::OP_DIV_ITER:
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
                psd_pkg::OP_DIV_INIT:
                begin
                    cnt_reg <= psd_pkg::DIV_LAST;
                end
                psd_pkg::OP_LEVEL:
                begin
                    filt_reg <= acc_reg[31:8];
                end
                psd_pkg::OP_EXTREMES:
                begin
                    if (filt_reg > peak_reg)
                    begin
                        peak_reg <= filt_reg;
                    end
                    if (filt_reg < trough_reg)
                    begin
                        trough_reg <= filt_reg;
                    end
                end
                psd_pkg::OP_TIMEOUT:
                begin
                    if (tmo_reg)
                    begin
                        armed_reg  <= 1'b0;
                        peak_reg   <= 24'd0;
                        trough_reg <= psd_pkg::TROUGH_RESET;
                    end
                end
                psd_pkg::OP_EDGE:
                begin
                    if (!armed_reg && (filt_reg > thr_q))
                    begin
                        armed_reg <= 1'b1;
                        rise_reg  <= now_reg;
                    end
                end
                psd_pkg::OP_FALL:
                begin
                    armed_reg  <= 1'b0;
                    peak_reg   <= 24'd0;
                    trough_reg <= psd_pkg::TROUGH_RESET;
                end
                psd_pkg::OP_CLAMP:
                begin
                    last_reg <= now_reg;
                    if (tally_reg != 32'hFFFF_FFFF)
                    begin
                        tally_reg <= tally_reg + 32'd1;
                    end
                end
                psd_pkg::OP_DIST:
                begin
                    dist_reg <= dist_sum[32] ? 32'hFFFF_FFFF : dist_sum[31:0];
                end
                default:
                begin
                end
            endcase

            // Output register: loaded at the end of a sample, freed by a taken beat.
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers without reset.
    always_ff @(posedge clk)
    begin
        if (ctrl.mul != psd_pkg::MUL_NONE)
        begin
            prod_reg <= 40'(mul_a) * 40'(mul_b);
        end
        acc_reg <= acc_next;

        case (ctrl.op)
            psd_pkg::OP_LOAD:
            begin
                if (fire)
                begin
                    ax_reg     <= samples.accel_x;
                    ay_reg     <= samples.accel_y;
                    az_reg     <= samples.accel_z;
                    now_reg    <= samples.time_ms;
                    event_reg  <= 1'b0;
                    stride_reg <= 11'd0;
                end
            end
            psd_pkg::OP_SQRT_INIT:
            begin
                rad_reg  <= acc_reg[31:0];
                rem_reg  <= 18'd0;
                root_reg <= 16'd0;
            end
            psd_pkg::OP_SQRT_ITER:
            begin
                rem_reg  <= sq_ge ? sq_diff[17:0] : sq_trial[17:0];
                root_reg <= {root_reg[14:0], sq_ge};
                rad_reg  <= {rad_reg[29:0], 2'b00};
            end
            psd_pkg::OP_EXTREMES:
            begin
                tmo_reg <= armed_reg && (rise_delta > {16'd0, cfg_regs.max_high_ms});
            end
            psd_pkg::OP_TIMEOUT:
            begin
                elap_reg <= now_reg - last_reg;
            end
            psd_pkg::OP_FALL:
            begin
                ok_reg <= (elap_reg > {16'd0, cfg_regs.min_interval_ms}) && swing_ok;
            end
            psd_pkg::OP_DIV_INIT:
            begin
                num_reg  <= psd_pkg::STRIDE_NUM;
                drem_reg <= 19'd0;
            end
            psd_pkg::OP_DIV_ITER:
            begin
                drem_reg <= dv_ge ? dv_diff[18:0] : dv_trial[18:0];
                num_reg  <= {num_reg[17:0], dv_ge};
            end
            psd_pkg::OP_CLAMP:
            begin
                event_reg  <= 1'b1;
                stride_reg <= stride_clamp;
            end
            default:
            begin
            end
        endcase

        if (emit)
        begin
            out_event_reg  <= event_reg;
            out_stride_reg <= stride_reg;
            out_tally_reg  <= tally_reg;
            out_dist_reg   <= dist_reg;
            out_level_reg  <= filt_reg;
        end
    end

    // Result channel.
    assign results.valid              = out_valid_reg;
    assign results.step_event         = out_event_reg;
    assign results.step_length_mm     = out_stride_reg;
    assign results.steps_total        = out_tally_reg;
    assign results.distance_mm        = out_dist_reg;
    assign results.smoothed_magnitude = out_level_reg;

    // The step count never goes backward.
    a_tally_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> tally_reg >= $past(tally_reg))
        else $error("step count decreased");

    // A counted step always carries a clamped stride.
    a_stride_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == psd_pkg::OP_CLAMP) |=> event_reg &&
        (stride_reg >= psd_pkg::STRIDE_MIN) && (stride_reg <= psd_pkg::STRIDE_MAX))
        else $error("stride outside its limits");

    // The square root loop stays put until its counter runs out.
    a_sqrt_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == psd_pkg::OP_SQRT_ITER && cnt_reg != 5'd0) |=>
        ctrl.op == psd_pkg::OP_SQRT_ITER)
        else $error("square root loop left early");

    // A falling edge disarms and restarts the extreme tracking.
    a_fall_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == psd_pkg::OP_FALL) |=>
        !armed_reg && (peak_reg == 24'd0) && (trough_reg == psd_pkg::TROUGH_RESET))
        else $error("falling edge did not reset the detector");

endmodule

`default_nettype wire

// ===== rtl/pedometer_step_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Threshold pedometer. Each sample beat carries three signed axes in mg and a
// wrapping millisecond timestamp. Each sample produces exactly one result beat with the
// smoothed magnitude (unsigned Q16.8), a step flag, the stride of that step and
// saturating step and distance totals. A small microcoded sequencer drives a
// single shared multiplier, a two-bit-per-cycle square root and a one-bit-per-cycle
// divider. After acceptance a sample is squared and summed, then passes the square
// root loop, the smoothing filter and the level, extreme, timeout and edge steps. A
// falling edge also runs the step check, and a counted step goes on through the
// stride division, the clamp and the distance update. The result is then loaded into
// the output register. The next sample can be accepted in the cycle after the previous
// result is loaded into the output register. The sequencer waits at its last step
// only while an older result has not yet been taken. Configuration writes are always
// ready and should be made while no sample is in flight.
module pedometer_step_detector
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    psd_cfg_if.sink       cfg,
    psd_sample_if.sink    samples,
    psd_result_if.source  results
);

    psd_pkg::cfg_regs_t cfg_regs_reg;
    psd_pkg::ucode_t    ctrl;
    psd_pkg::status_t   status;

    assign cfg.ready = 1'b1;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg.threshold_mg    <= psd_pkg::THRESHOLD_RESET;
            cfg_regs_reg.min_interval_ms <= psd_pkg::MIN_INTERVAL_RESET;
            cfg_regs_reg.max_high_ms     <= psd_pkg::MAX_HIGH_RESET;
            cfg_regs_reg.min_swing_mg    <= psd_pkg::MIN_SWING_RESET;
            cfg_regs_reg.smoothing_q8    <= psd_pkg::SMOOTHING_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                psd_pkg::REG_THRESHOLD:    cfg_regs_reg.threshold_mg    <= cfg.data;
                psd_pkg::REG_MIN_INTERVAL: cfg_regs_reg.min_interval_ms <= cfg.data;
                psd_pkg::REG_MAX_HIGH:     cfg_regs_reg.max_high_ms     <= cfg.data;
                psd_pkg::REG_MIN_SWING:    cfg_regs_reg.min_swing_mg    <= cfg.data;
                psd_pkg::REG_SMOOTHING:    cfg_regs_reg.smoothing_q8    <= cfg.data[8:0];
                default:
                begin
                end
            endcase
        end
    end

    // Program sequencer.
    psd_sequencer u_sequencer
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // Datapath.
    psd_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_regs_reg),
        .ctrl     (ctrl),
        .status   (status),
        .samples  (samples),
        .results  (results)
    );

endmodule

`default_nettype wire

// ===== tb/sv/psd_step_checker.sv =====
`timescale 1ns / 1ps

// Watches the configuration, sample and result channels of the pedometer.
// Keeps its own model of the gait tracker, predicts one result per accepted
// sample beat and compares every accepted result beat with the oldest prediction.
module psd_step_checker
(
    input  logic        clk,
    input  logic        rst_n,
    psd_cfg_if          cfg,
    psd_sample_if       samples,
    psd_result_if       results,
    output int unsigned mismatches,
    output int unsigned reports_due
);

    typedef struct packed {
        logic        stepped;
        logic [10:0] stride_mm;
        logic [31:0] steps;
        logic [31:0] distance;
        logic [23:0] level;
    } gait_report_t;

    // Shadow copy of the configuration registers.
    logic [15:0] thr_mg;
    logic [15:0] min_gap_ms;
    logic [15:0] max_high_ms;
    logic [15:0] min_swing_mg;
    logic [8:0]  weight_q8;

    // Gait tracker state.
    logic [23:0] level;
    logic [23:0] peak;
    logic [23:0] trough;
    logic        armed;
    logic [31:0] last_step_ms;
    logic [31:0] rise_ms;
    logic [31:0] walked_steps;
    logic [31:0] distance;

    gait_report_t pending_reports[$];
    int unsigned  result_index;

    // Floor square root, built one result bit at a time from the top.
    function automatic logic [15:0] floor_root(input logic [31:0] v);
        logic [15:0] root;
        logic [31:0] trial;
        int          b;
        root = '0;
        for (b = 15; b >= 0; b--)
        begin
            trial = {16'd0, root | (16'd1 << b)};
            if (trial * trial <= v)
                root = trial[15:0];
        end
        return root;
    endfunction

    // Advance the tracker by one sample and return the result it should produce.
    function automatic gait_report_t track_sample(input logic signed [15:0] ax,
                                                  input logic signed [15:0] ay,
                                                  input logic signed [15:0] az,
                                                  input logic [31:0] now);
        gait_report_t rpt;
        int           sx;
        int           sy;
        int           sz;
        logic [31:0]  energy;
        logic [63:0]  w64;
        logic [63:0]  mag64;
        logic [63:0]  mix;
        logic [31:0]  thr_q;
        logic [31:0]  elapsed;
        logic [31:0]  held_ms;
        logic [31:0]  swing;
        logic [31:0]  stride;
        sx = ax;
        sy = ay;
        sz = az;
        energy = 32'(sx * sx) + 32'(sy * sy) + 32'(sz * sz);
        w64 = (weight_q8 > psd_pkg::WEIGHT_FULL) ? 64'(psd_pkg::WEIGHT_FULL)
                                                 : 64'(weight_q8);
        mag64 = {40'd0, floor_root(energy), 8'd0};
        mix = w64 * mag64 + (64'd256 - w64) * {40'd0, level} + 64'd128;
        level = mix[31:8];
        rpt = '0;
        stride = '0;
        elapsed = now - last_step_ms;

        if (level > peak)
            peak = level;
        if (level < trough)
            trough = level;

        // Staying above the threshold too long drops the armed state.
        held_ms = now - rise_ms;
        if (armed && held_ms > {16'd0, max_high_ms})
        begin
            armed = 1'b0;
            peak = '0;
            trough = psd_pkg::TROUGH_RESET;
        end

        thr_q = {8'd0, thr_mg, 8'd0};
        if (!armed && {8'd0, level} > thr_q)
        begin
            armed = 1'b1;
            rise_ms = now;
        end
        else if (armed && {8'd0, level} < thr_q)
        begin
            swing = (peak > trough) ? {8'd0, peak - trough} : 32'd0;
            armed = 1'b0;
            if (elapsed > {16'd0, min_gap_ms} && swing > {8'd0, min_swing_mg, 8'd0})
            begin
                stride = {13'd0, psd_pkg::STRIDE_NUM} / elapsed;
                if (stride < {21'd0, psd_pkg::STRIDE_MIN})
                    stride = {21'd0, psd_pkg::STRIDE_MIN};
                if (stride > {21'd0, psd_pkg::STRIDE_MAX})
                    stride = {21'd0, psd_pkg::STRIDE_MAX};
                rpt.stepped = 1'b1;
                last_step_ms = now;
                if (walked_steps != '1)
                    walked_steps = walked_steps + 1;
                if (distance > 32'hFFFF_FFFF - stride)
                    distance = '1;
                else
                    distance = distance + stride;
            end
            peak = '0;
            trough = psd_pkg::TROUGH_RESET;
        end

        rpt.stride_mm = stride[10:0];
        rpt.steps = walked_steps;
        rpt.distance = distance;
        rpt.level = level;
        return rpt;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen)
        begin
            $error("result %0d %s: expected %0d, got %0d", result_index, name, want, seen);
            mismatches++;
        end
    endtask

    // Result beats are checked before a sample beat of the same edge is queued.
    always @(posedge clk or negedge rst_n)
    begin
        gait_report_t want;
        if (!rst_n)
        begin
            thr_mg = psd_pkg::THRESHOLD_RESET;
            min_gap_ms = psd_pkg::MIN_INTERVAL_RESET;
            max_high_ms = psd_pkg::MAX_HIGH_RESET;
            min_swing_mg = psd_pkg::MIN_SWING_RESET;
            weight_q8 = psd_pkg::SMOOTHING_RESET;
            level = psd_pkg::LEVEL_RESET;
            peak = '0;
            trough = psd_pkg::TROUGH_RESET;
            armed = 1'b0;
            last_step_ms = '0;
            rise_ms = '0;
            walked_steps = '0;
            distance = '0;
            pending_reports.delete();
            result_index = 0;
            mismatches = 0;
            reports_due = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    psd_pkg::REG_THRESHOLD:    thr_mg = cfg.data;
                    psd_pkg::REG_MIN_INTERVAL: min_gap_ms = cfg.data;
                    psd_pkg::REG_MAX_HIGH:     max_high_ms = cfg.data;
                    psd_pkg::REG_MIN_SWING:    min_swing_mg = cfg.data;
                    psd_pkg::REG_SMOOTHING:    weight_q8 = cfg.data[8:0];
                    default:                   ;
                endcase
            end

            if (results.valid && results.ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("result beat %0d arrived with no sample outstanding",
                           result_index);
                    mismatches++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("step_event", 32'(want.stepped), 32'(results.step_event));
                    check_field("step_length_mm", 32'(want.stride_mm),
                                32'(results.step_length_mm));
                    check_field("steps_total", want.steps, results.steps_total);
                    check_field("distance_mm", want.distance, results.distance_mm);
                    check_field("smoothed_magnitude", 32'(want.level),
                                32'(results.smoothed_magnitude));
                end
                result_index++;
            end

            if (samples.valid && samples.ready)
                pending_reports.push_back(track_sample(samples.accel_x, samples.accel_y,
                                                       samples.accel_z, samples.time_ms));

            reports_due = pending_reports.size();
        end
    end

endmodule

// ===== tb/sv/tb_pedometer_step_detector.sv =====
`timescale 1ns / 1ps

// Drives the pedometer with directed corner samples and then with phases of
// walking-like sequences and noise under several register settings. The checker
// beside the block does all prediction and comparison.
module tb_pedometer_step_detector;

    localparam int       HALF_PERIOD   = 2;
    localparam int       CYCLE_LIMIT   = 1_000_000;
    localparam int       RANDOM_ITEMS  = 1900;
    localparam int       PHASES        = 8;
    localparam int       SETTLE_CYCLES = 80;
    localparam int       HOLD_CYCLES   = 300;
    localparam psd_pkg::cfg_idx_t REG_SPARE_FIRST = 3'd5;
    localparam psd_pkg::cfg_idx_t REG_SPARE_LAST  = 3'd7;

    logic        clk;
    logic        rst_n;
    int unsigned mismatches;
    int unsigned reports_due;
    int unsigned cycle_count;
    logic [15:0] threshold_now;
    logic [31:0] clock_ms;
    bit          smooth_flow;

    psd_cfg_if    cfg_ch ();
    psd_sample_if sample_ch ();
    psd_result_if result_ch ();

    pedometer_step_detector dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .samples (sample_ch),
        .results (result_ch)
    );

    psd_step_checker gait_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .samples     (sample_ch),
        .results     (result_ch),
        .mismatches  (mismatches),
        .reports_due (reports_due)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // Run limit.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("pedometer_step_detector verification failed");
        $finish;
    end

    // Result side: random stalls per beat, calm stretches, and two long hold-offs
    // that back the block up into its sample input.
    initial
    begin
        int unsigned beats;
        int unsigned stall;
        bit          steady;
        result_ch.ready = 1'b0;
        beats = 0;
        steady = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (beats % 64 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (beats == 150 || beats == 1200)
                stall = HOLD_CYCLES;
            else
                stall = steady ? 0 : $urandom_range(0, 4);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            beats++;
        end
    end

    // Offer one sample beat and wait until it is taken.
    task automatic push_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                               input logic signed [15:0] az, input logic [31:0] now);
        int unsigned gap;
        gap = smooth_flow ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.accel_x <= ax;
        sample_ch.accel_y <= ay;
        sample_ch.accel_z <= az;
        sample_ch.time_ms <= now;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    // Stop offering samples and wait until every predicted result has come back.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
    endtask

    // Leaves the write channel valid so back-to-back writes need no gap.
    task automatic write_reg(input psd_pkg::cfg_idx_t idx, input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // Program all registers while idle, plus writes to unused indexes.
    task automatic program_regs(input logic [15:0] thr, input logic [15:0] gap,
                                input logic [15:0] high, input logic [15:0] swing,
                                input logic [15:0] weight);
        int i;
        settle();
        write_reg(psd_pkg::REG_THRESHOLD, thr);
        write_reg(psd_pkg::REG_MIN_INTERVAL, gap);
        write_reg(psd_pkg::REG_MAX_HIGH, high);
        write_reg(psd_pkg::REG_MIN_SWING, swing);
        write_reg(psd_pkg::REG_SMOOTHING, weight);
        for (i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
            write_reg(psd_pkg::cfg_idx_t'(i), 16'($urandom));
        cfg_ch.valid <= 1'b0;
        threshold_now = thr;
    endtask

    // A walking-like sequence: the vertical axis swings above and below the
    // threshold with a random cadence, small side axes and jittered timing.
    task automatic walk(input int unsigned count);
        int          thr;
        int          hi;
        int          lo;
        int          mag;
        int unsigned half_len;
        int unsigned dt;
        int unsigned k;
        thr = threshold_now;
        hi = thr + $urandom_range(150, 900);
        if (hi > 32767)
            hi = 32767;
        lo = thr - int'($urandom_range(150, 700));
        if (lo < 0)
            lo = $urandom_range(0, 200);
        if (lo > 32767)
            lo = 32767;
        half_len = $urandom_range(3, 30);
        dt = $urandom_range(4, 25);
        if ($urandom_range(0, 9) == 0)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
        for (k = 0; k < count; k++)
        begin
            mag = (((k / half_len) % 2) == 0) ? hi : lo;
            mag = mag + int'($urandom_range(0, 60)) - 30;
            if (mag < 0)
                mag = 0;
            if (mag > 32767)
                mag = 32767;
            if ($urandom_range(0, 40) == 0)
                clock_ms = clock_ms + $urandom_range(0, 3000);
            else
                clock_ms = clock_ms + dt;
            push_sample(16'(int'($urandom_range(0, 240)) - 120),
                        16'(int'($urandom_range(0, 240)) - 120),
                        $urandom_range(0, 1) ? 16'(mag) : 16'(-mag), clock_ms);
        end
    endtask

    // Full-range samples with random or jumping timestamps.
    task automatic noise(input int unsigned count);
        int unsigned k;
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 1) == 0)
                clock_ms = $urandom;
            else
                clock_ms = clock_ms + $urandom_range(0, 50);
            push_sample(16'($urandom), 16'($urandom), 16'($urandom), clock_ms);
        end
    endtask

    initial
    begin
        int          phase;
        int unsigned sent;
        int unsigned n;
        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.accel_x = '0;
        sample_ch.accel_y = '0;
        sample_ch.accel_z = '0;
        sample_ch.time_ms = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = psd_pkg::REG_THRESHOLD;
        cfg_ch.data = '0;
        threshold_now = psd_pkg::THRESHOLD_RESET;
        clock_ms = '0;
        smooth_flow = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes under the reset settings.
        push_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'd0);
        push_sample(-16'sd32768, -16'sd32768, -16'sd32768, 32'hFFFF_FFFF);
        push_sample(16'sd0, 16'sd0, 16'sd0, 32'd1);
        push_sample(-16'sd32768, 16'sd32767, 16'sd0, 32'd2000);
        push_sample(16'sd1, -16'sd1, -16'sd32768, 32'd2600);

        // Raw magnitude passes straight through, so edges land on exact samples.
        program_regs(16'd1000, 16'd0, 16'd100, 16'd0, 16'd256);
        // Level equal to the threshold: neither edge.
        push_sample(16'sd1000, 16'sd0, 16'sd0, 32'd10);
        push_sample(16'sd0, 16'sd2000, 16'sd0, 32'd20);
        // Timeout disarms and re-arms on the same sample.
        push_sample(16'sd0, 16'sd0, 16'sd2000, 32'd200);
        // Fall right after the timeout: no swing, no step.
        push_sample(16'sd0, 16'sd0, 16'sd500, 32'd250);
        // Ordinary step with an unclamped stride.
        push_sample(16'sd0, 16'sd0, 16'sd2000, 32'd300);
        push_sample(16'sd0, 16'sd0, 16'sd100, 32'd400);
        // Quick step: stride clamps high.
        push_sample(16'sd0, 16'sd0, 16'sd2000, 32'd450);
        push_sample(16'sd0, 16'sd0, 16'sd100, 32'd500);
        // Zero elapsed time never counts.
        push_sample(16'sd2000, 16'sd0, 16'sd0, 32'd500);
        push_sample(16'sd100, 16'sd0, 16'sd0, 32'd500);
        // Slow step: stride clamps low.
        push_sample(16'sd2000, 16'sd0, 16'sd0, 32'd1500);
        push_sample(16'sd100, 16'sd0, 16'sd0, 32'd1550);
        // Timestamp wraps between the last step and this one.
        push_sample(16'sd2000, 16'sd0, 16'sd0, 32'hFFFF_FFF0);
        push_sample(16'sd100, 16'sd0, 16'sd0, 32'h0000_0010);

        // Weights above full scale saturate, including upper data bits.
        program_regs(16'd1150, 16'd500, 16'd2000, 16'd150, 16'hFFFF);
        push_sample(16'sd300, -16'sd400, 16'sd1200, 32'h0000_0100);
        program_regs(16'd1150, 16'd500, 16'd2000, 16'd150, 16'd257);
        push_sample(16'sd0, 16'sd0, 16'sd3000, 32'h0000_0200);
        // Zero weight freezes the level.
        program_regs(16'd1150, 16'd500, 16'd2000, 16'd150, 16'd0);
        push_sample(16'sd0, 16'sd0, -16'sd3000, 32'h0000_0300);

        // Random phases, each under its own register setting.
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: program_regs(psd_pkg::THRESHOLD_RESET, psd_pkg::MIN_INTERVAL_RESET,
                                psd_pkg::MAX_HIGH_RESET, psd_pkg::MIN_SWING_RESET,
                                16'(psd_pkg::SMOOTHING_RESET));
                1: program_regs(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd256);
                2: program_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
                3: program_regs(16'd1100, 16'd200, 16'd300, 16'd100, 16'd128);
                default:
                    program_regs(16'($urandom_range(700, 1500)), 16'($urandom_range(0, 800)),
                                 16'($urandom_range(0, 2500)), 16'($urandom_range(0, 300)),
                                 ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(20, 256)));
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS / PHASES)
            begin
                smooth_flow = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 4) == 0)
                begin
                    n = $urandom_range(1, 10);
                    noise(n);
                end
                else
                begin
                    n = $urandom_range(20, 90);
                    // Keep each phase close to its share of the item budget.
                    if (n > RANDOM_ITEMS / PHASES - sent)
                        n = RANDOM_ITEMS / PHASES - sent;
                    walk(n);
                end
                sent += n;
            end
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && reports_due == 0)
            $display("pedometer_step_detector verification clean");
        else
            $display("pedometer_step_detector verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/psd_pkg.sv
rtl/psd_if.sv
rtl/psd_sequencer.sv
rtl/psd_datapath.sv
rtl/pedometer_step_detector.sv
tb/sv/psd_step_checker.sv
tb/sv/tb_pedometer_step_detector.sv
